/* hdl/ppmd_pkg.sv */
// ----------------------------------------------------------------------------
// ppmd_pkg
// Shared widths, reset values and codes of the PPM sum signal decoder.
// ----------------------------------------------------------------------------
package ppmd_pkg;

    localparam int NUM_CHANNELS_DEFAULT = 8;

    localparam int TIME_W      = 16;
    localparam int WIDTH_W     = 12;
    localparam int VALUE_W     = 13;
    localparam int SLOT_W      = 3;
    localparam int CHAN_W      = 3;
    localparam int MAP_W       = 24;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;

    localparam logic [MAP_W-1:0]   CHANNEL_MAP_RESET = 24'hFAC688;
    localparam logic [TIME_W-1:0]  SYNC_GAP_RESET    = 16'd3000;
    localparam logic [TIME_W-1:0]  MIN_WIDTH_RESET   = 16'd900;
    localparam logic [TIME_W-1:0]  MAX_WIDTH_RESET   = 16'd2200;

    localparam logic [WIDTH_W-1:0] RESET_WIDTH  = 12'd1500;
    localparam logic [WIDTH_W-1:0] WIDTH_MAX    = 12'd4095;
    localparam logic signed [VALUE_W-1:0] SCALE_OFFSET = 13'sd1000;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_MAP = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_GAP    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_WIDTH   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_WIDTH   = 2'd3;

    typedef enum logic [1:0] {
        OP_EDGE        = 2'd0,
        OP_READ_RAW    = 2'd1,
        OP_READ_SCALED = 2'd2
    } op_t;

    // read request travelling with the memory read
    typedef struct packed {
        logic scaled;
        logic slot_ok;
    } rd_info_t;

endpackage

/* hdl/ppmd_ram.sv */
// ----------------------------------------------------------------------------
// ppmd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ppmd_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hdl/ppmd_edge.sv */
// ----------------------------------------------------------------------------
// ppmd_edge
// Edge tracker: forms the interval between rising edges, detects the frame
// sync, counts channels and issues width writes plus per-slot valid bits.
// ----------------------------------------------------------------------------
module ppmd_edge #(
    parameter int NUM_CHANNELS = ppmd_pkg::NUM_CHANNELS_DEFAULT,
    parameter int ADDR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        edge_accept,
    input  logic [ppmd_pkg::TIME_W-1:0] edge_time,
    input  logic [ppmd_pkg::TIME_W-1:0] sync_gap,
    input  logic [ppmd_pkg::TIME_W-1:0] min_width,
    input  logic [ppmd_pkg::TIME_W-1:0] max_width,
    output logic                        wr_en,
    output logic [ADDR_W-1:0]           wr_addr,
    output logic [ppmd_pkg::WIDTH_W-1:0] wr_data,
    output logic [NUM_CHANNELS-1:0]     slot_valid
);

    import ppmd_pkg::*;

    localparam int CIDX_W = $clog2(NUM_CHANNELS + 1);
    localparam logic [CIDX_W-1:0] CIDX_LIMIT = CIDX_W'(NUM_CHANNELS);

    logic [TIME_W-1:0]       last_edge_time_reg, last_edge_time_next;
    logic [CIDX_W-1:0]       channel_index_reg, channel_index_next;
    logic [NUM_CHANNELS-1:0] slot_valid_reg, slot_valid_next;
    logic [TIME_W-1:0]       diff;
    logic                    is_sync;
    logic                    in_window;

    assign diff      = edge_time - last_edge_time_reg;
    assign is_sync   = diff > sync_gap;
    assign in_window = (diff > min_width) && (diff < max_width);

    always_comb
    begin
        last_edge_time_next = last_edge_time_reg;
        channel_index_next  = channel_index_reg;
        slot_valid_next     = slot_valid_reg;
        wr_en               = 1'b0;
        wr_addr             = channel_index_reg[ADDR_W-1:0];
        // clamp intervals that do not fit the stored width
        wr_data             = (diff[TIME_W-1:WIDTH_W] != '0) ? WIDTH_MAX : diff[WIDTH_W-1:0];
        if (edge_accept)
        begin
            last_edge_time_next = edge_time;
            if (is_sync)
            begin
                channel_index_next = '0;
            end
            else if (channel_index_reg < CIDX_LIMIT)
            begin
                if (in_window)
                begin
                    wr_en = 1'b1;
                    slot_valid_next[channel_index_reg[ADDR_W-1:0]] = 1'b1;
                end
                channel_index_next = channel_index_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_edge_time_reg <= '0;
            channel_index_reg  <= '0;
            slot_valid_reg     <= '0;
        end
        else
        begin
            last_edge_time_reg <= last_edge_time_next;
            channel_index_reg  <= channel_index_next;
            slot_valid_reg     <= slot_valid_next;
        end
    end

    assign slot_valid = slot_valid_reg;

    a_index_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        channel_index_reg <= CIDX_LIMIT)
        else $error("channel count beyond limit");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (channel_index_reg < CIDX_LIMIT) && !is_sync)
        else $error("width write outside a counted channel");

    a_sync_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        edge_accept && is_sync |=> channel_index_reg == '0)
        else $error("sync did not restart channel count");

endmodule

/* hdl/ppmd_out.sv */
// ----------------------------------------------------------------------------
// ppmd_out
// Read result stage: substitutes the reset width for unwritten or missing
// slots, applies the optional scaling and holds the result for the consumer.
// ----------------------------------------------------------------------------
module ppmd_out (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s1_valid,
    input  ppmd_pkg::rd_info_t             s1_info,
    input  logic [ppmd_pkg::WIDTH_W-1:0]   rd_data,
    output logic                           s1_ready,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [ppmd_pkg::VALUE_W-1:0] value
);

    import ppmd_pkg::*;

    logic                      out_valid_reg, out_valid_next;
    logic signed [VALUE_W-1:0] value_reg, value_next;
    logic [WIDTH_W-1:0]        width;
    logic signed [VALUE_W-1:0] offset_width;
    logic signed [VALUE_W-1:0] scaled;

    assign width        = s1_info.slot_ok ? rd_data : RESET_WIDTH;
    assign offset_width = $signed({1'b0, width}) - SCALE_OFFSET;
    // divide by four, truncating toward zero
    assign scaled       = offset_width[VALUE_W-1] ? ((offset_width + 13'sd3) >>> 2)
                                                  : (offset_width >>> 2);

    assign s1_ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        value_next     = value_reg;
        if (s1_ready)
        begin
            out_valid_next = s1_valid;
            if (s1_valid)
            begin
                value_next = s1_info.scaled ? scaled : $signed({1'b0, width});
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;

endmodule

/* hdl/ppm_sum_signal_decoder_unit.sv */
// ----------------------------------------------------------------------------
// ppm_sum_signal_decoder_unit
// PPM sum signal decoder with mapped, optionally scaled channel reads.
// ----------------------------------------------------------------------------
// The unit takes one request per cycle, edge or read, while in_stall is low. An
// edge request updates the interval tracker, writes the pulse width memory for
// an in-window interval in the cycle it is accepted and produces no result. A
// read request looks up the mapped slot in the width memory when it is
// accepted; its read data waits in the memory stage and is then loaded into
// the output register when that register can take it. Slots that were never
// written since reset read as 1500 (125 when scaled) through
// per-slot valid bits, so the unit is ready right after reset with no clear
// pass. Input requests stall only while a read result waits in the memory
// stage and the output register is full and stalled.
module ppm_sum_signal_decoder_unit #(
    parameter int NUM_CHANNELS = ppmd_pkg::NUM_CHANNELS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [ppmd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ppmd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        operation,
    input  logic [ppmd_pkg::TIME_W-1:0]       edge_time,
    input  logic [ppmd_pkg::CHAN_W-1:0]       channel,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [ppmd_pkg::VALUE_W-1:0] value
);

    import ppmd_pkg::*;

    localparam int ADDR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int SLOT_CMP_W = SLOT_W + 2;

    logic [MAP_W-1:0]  channel_map_reg;
    logic [TIME_W-1:0] sync_gap_reg;
    logic [TIME_W-1:0] min_width_reg;
    logic [TIME_W-1:0] max_width_reg;

    logic                    accept;
    logic                    edge_accept;
    logic                    read_accept;
    logic [SLOT_W-1:0]       slot;
    logic [ADDR_W-1:0]       rd_addr;
    logic                    slot_exists;
    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic [WIDTH_W-1:0]      wr_data;
    logic [WIDTH_W-1:0]      rd_data;
    logic [NUM_CHANNELS-1:0] slot_valid;
    logic                    s1_ready;
    logic                    s1_valid_reg, s1_valid_next;
    rd_info_t                s1_info_reg, s1_info_next;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_map_reg <= CHANNEL_MAP_RESET;
            sync_gap_reg    <= SYNC_GAP_RESET;
            min_width_reg   <= MIN_WIDTH_RESET;
            max_width_reg   <= MAX_WIDTH_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_CHANNEL_MAP: channel_map_reg <= cfg_data[MAP_W-1:0];
                CFG_SYNC_GAP:    sync_gap_reg    <= cfg_data[TIME_W-1:0];
                CFG_MIN_WIDTH:   min_width_reg   <= cfg_data[TIME_W-1:0];
                CFG_MAX_WIDTH:   max_width_reg   <= cfg_data[TIME_W-1:0];
                default:         ;
            endcase
        end
    end

    assign in_stall = s1_valid_reg && !s1_ready;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        edge_accept = 1'b0;
        read_accept = 1'b0;
        case (operation)
            OP_EDGE:        edge_accept = accept;
            OP_READ_RAW:    read_accept = accept;
            OP_READ_SCALED: read_accept = accept;
            default:        ;
        endcase
    end

    assign slot        = channel_map_reg[SLOT_W*channel +: SLOT_W];
    assign rd_addr     = ADDR_W'(slot);
    assign slot_exists = SLOT_CMP_W'(slot) < SLOT_CMP_W'(NUM_CHANNELS);

    ppmd_edge #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .ADDR_W       (ADDR_W)
    ) u_edge (
        .clk         (clk),
        .rst_n       (rst_n),
        .edge_accept (edge_accept),
        .edge_time   (edge_time),
        .sync_gap    (sync_gap_reg),
        .min_width   (min_width_reg),
        .max_width   (max_width_reg),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .slot_valid  (slot_valid)
    );

    ppmd_ram #(
        .WIDTH  (WIDTH_W),
        .DEPTH  (NUM_CHANNELS),
        .ADDR_W (ADDR_W)
    ) u_width_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (read_accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // memory read stage; read data holds while this stage is stalled
    always_comb
    begin
        s1_info_next  = s1_info_reg;
        s1_valid_next = s1_valid_reg && !s1_ready;
        if (read_accept)
        begin
            s1_valid_next        = 1'b1;
            s1_info_next.scaled  = (operation == OP_READ_SCALED);
            s1_info_next.slot_ok = slot_exists && slot_valid[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_info_reg <= s1_info_next;
    end

    ppmd_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_valid  (s1_valid_reg),
        .s1_info   (s1_info_reg),
        .rd_data   (rd_data),
        .s1_ready  (s1_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value)
    );

    a_read_enters_stage: assert property (@(posedge clk) disable iff (!rst_n)
        read_accept |=> s1_valid_reg)
        else $error("accepted read request lost before memory stage");

    a_stage_drains: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_ready && !read_accept |=> !s1_valid_reg)
        else $error("read result duplicated in memory stage");

    a_stage_feeds_output: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_ready |=> out_valid)
        else $error("read result did not reach output register");

    a_no_write_with_read: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && read_accept))
        else $error("width write and read in the same cycle");

endmodule
